[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, reset included.
`define BB3_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define BB3_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[sv/bb3_pkg.sv]
// Shared constants and types of the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WID_W        = COL_W + 1;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int ROW_W  = 13;
    localparam int OROW_W = 12;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_4 = 2'd0,
        DIV_6 = 2'd1,
        DIV_9 = 2'd2
    } t_div;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
        logic             last;
    } t_cmd;

endpackage

[sv/bb3_if.sv]
// Stream and configuration channel interfaces of the 3x3 RGB box blur.
interface bb3_pix_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface bb3_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/bb3_front.sv]
// Front end: configuration registers, position counters and item classification.
module bb3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bb3_pix_if.sink       i_pix,
    bb3_cfg_if.sink       i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output bb3_pkg::t_cmd o_cmd
);
    import bb3_pkg::*;

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    logic [WID_W-1:0] w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [WID_W-1:0] col_inc;
    logic [WID_W-1:0] out_col_inc;
    logic [FH_W-1:0]  out_row_inc;
    logic             col_wrap;
    logic             expecting;
    logic             accept;
    logic             drop;
    logic             emit;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes clamped to the supported range
    always_comb begin
        if (r_frame_width < FW_W'(2)) begin
            w_eff = WID_W'(2);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_frame_width);
        end
        if (r_frame_height < FH_W'(2)) begin
            h_eff = FH_W'(2);
        end else if (int'(r_frame_height) > HEIGHT_LIMIT) begin
            h_eff = FH_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !i_q_full;

    assign col_inc     = {1'b0, r_in_col} + WID_W'(1);
    assign col_wrap    = col_inc >= w_eff;
    assign expecting   = r_in_row < h_eff;
    assign drop        = expecting && i_pix.operation;
    assign emit        = (r_in_row > ROW_W'(1)) || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));

    assign out_col_inc = {1'b0, r_out_col} + WID_W'(1);
    assign out_row_inc = {1'b0, r_out_row} + FH_W'(1);
    assign top         = r_out_row == '0;
    assign bottom      = out_row_inc >= h_eff;
    assign left        = r_out_col == '0;
    assign right       = out_col_inc >= w_eff;
    assign last        = bottom && right;

    assign o_push = accept && !drop;

    always_comb begin
        o_cmd.pix    = expecting ? {i_pix.red_in, i_pix.green_in, i_pix.blue_in} : '0;
        o_cmd.col    = r_in_col;
        o_cmd.emit   = emit;
        o_cmd.top    = top;
        o_cmd.bottom = bottom;
        o_cmd.left   = left;
        o_cmd.right  = right;
        o_cmd.last   = last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (o_push) begin
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (right) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OROW_W'(1);
                end else begin
                    n_out_col = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

[sv/bb3_queue.sv]
// Short command queue decoupling the front end from the back end.
module bb3_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bb3_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bb3_pkg::t_cmd o_cmd
);
    import bb3_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

endmodule

[sv/bb3_back.sv]
// Back end: line store, 3x3 window, masked sums, rounded means and result register.
module bb3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bb3_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    bb3_res_if.source     o_res
);
    import bb3_pkg::*;

    localparam int                 PROD_W  = 2 * SUM_W;
    localparam logic [SUM_W-1:0]   RECIP_3 = SUM_W'(2731);
    localparam int                 SHIFT_3 = 13;
    localparam logic [SUM_W-1:0]   RECIP_9 = SUM_W'(3641);
    localparam int                 SHIFT_9 = 15;

    // Each entry holds {row before last, last row} for one column
    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_mem_q;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd;

    logic               advance;
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic               r_s2_valid;
    t_cmd               r_s2_cmd;
    logic               r_s3_valid;
    t_cmd               r_s3_cmd;
    logic               r_s4_valid;
    logic               r_s4_last;
    t_div               r_s4_div;
    logic [SUM_W-1:0]   r_s4_sum [3];

    logic [PIX_W-1:0]   r_win [3][3];

    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_red;
    logic [CH_W-1:0]    r_out_green;
    logic [CH_W-1:0]    r_out_blue;
    logic               r_out_last;

    logic [2*PIX_W-1:0] line_q;
    logic [2*PIX_W-1:0] wr_data;
    logic [2:0]         row_en;
    logic [2:0]         col_en;
    logic [SUM_W-1:0]   sums [3];
    t_div               div;

    function automatic logic [CH_W-1:0] rounded_mean(input logic [SUM_W-1:0] sum,
                                                     input t_div d);
        logic [SUM_W-1:0]  y;
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   q;
        y    = '0;
        prod = '0;
        q    = '0;
        case (d)
            DIV_4: begin
                y = sum + SUM_W'(2);
                q = CH_W'(y >> 2);
            end
            DIV_6: begin
                y    = (sum + SUM_W'(3)) >> 1;
                prod = y * RECIP_3;
                q    = CH_W'(prod >> SHIFT_3);
            end
            DIV_9: begin
                y    = sum + SUM_W'(4);
                prod = y * RECIP_9;
                q    = CH_W'(prod >> SHIFT_9);
            end
            default: q = '0;
        endcase
        return q;
    endfunction

    assign advance = !r_out_valid || o_res.ready;
    assign o_pop   = advance && i_q_valid;

    // Line store read data, bypassed when the previous item wrote the same column
    assign line_q  = r_fwd ? r_fwd_data : r_mem_q;
    assign wr_data = {line_q[PIX_W-1:0], r_s2_cmd.pix};

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_s2_valid) begin
                r_line[r_s2_cmd.col] <= wr_data;
            end
            r_mem_q <= r_line[r_s1_cmd.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd   <= i_q_cmd;
            r_s2_cmd   <= r_s1_cmd;
            r_s3_cmd   <= r_s2_cmd;
            r_fwd_data <= wr_data;
            r_s4_last  <= r_s3_cmd.last;
            r_s4_div   <= div;
            for (int ch = 0; ch < 3; ch++) begin
                r_s4_sum[ch] <= sums[ch];
            end
            if (r_s4_valid) begin
                r_out_red   <= rounded_mean(r_s4_sum[2], r_s4_div);
                r_out_green <= rounded_mean(r_s4_sum[1], r_s4_div);
                r_out_blue  <= rounded_mean(r_s4_sum[0], r_s4_div);
                r_out_last  <= r_s4_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid && r_s2_cmd.emit;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
            r_fwd       <= r_s2_valid && (r_s2_cmd.col == r_s1_cmd.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (advance && r_s2_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_q[2*PIX_W-1:PIX_W];
            r_win[1][2] <= line_q[PIX_W-1:0];
            r_win[2][2] <= r_s2_cmd.pix;
        end
    end

    // Masked neighbourhood sums over the window of the item in stage three
    assign row_en = {!r_s3_cmd.bottom, 1'b1, !r_s3_cmd.top};
    assign col_en = {!r_s3_cmd.right, 1'b1, !r_s3_cmd.left};

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sums[ch] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_en[r] && col_en[c]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        sums[ch] = sums[ch] + SUM_W'(r_win[r][c][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    always_comb begin
        if ((r_s3_cmd.top || r_s3_cmd.bottom) && (r_s3_cmd.left || r_s3_cmd.right)) begin
            div = DIV_4;
        end else if (r_s3_cmd.top || r_s3_cmd.bottom || r_s3_cmd.left || r_s3_cmd.right) begin
            div = DIV_6;
        end else begin
            div = DIV_9;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.red_out   = r_out_red;
    assign o_res.green_out = r_out_green;
    assign o_res.blue_out  = r_out_blue;
    assign o_res.frame_end = r_out_last;

endmodule

[sv/box_blur_3x3_rgb_unit.sv]
// Top level of the 3x3 RGB box blur.
// Takes RGB pixels in raster order and returns, per colour channel, the mean of each
// pixel's in-frame 3x3 neighbourhood (9, 6 or 4 pixels), rounded half up. Results lag
// the input by one row plus one pixel; after the last pixel of a frame send
// frame_width+1 items with operation set to drain it, and the last result carries
// frame_end. One pixel is accepted per clock while the result channel does not stall:
// the front end classifies an item in the cycle it is transferred, and the back end
// reads and writes the 1024 x 48-bit line store once each per clock it advances, then
// registers the window, masked sums and rounded means in stage s3, stage s4 and the
// result register. Stalls on the result channel hold the back end while up to two items
// queue ahead of it. The line store needs no clearing after reset. Frames must be at
// least 2 x 2 pixels; sizes must be set only while idle; the block does not check it.
module box_blur_3x3_rgb_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bb3_pix_if.sink   i_pix,
    bb3_cfg_if.sink   i_cfg,
    bb3_res_if.source o_res
);
    import bb3_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    bb3_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bb3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

[sv/bb3_checker.sv]
// Port-level checks of the 3x3 RGB box blur and their binding to the top level.
`include "assert_macros.svh"

module bb3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_res_red,
    input logic [7:0] i_res_green,
    input logic [7:0] i_res_blue,
    input logic       i_res_last
);

    `BB3_ASSERT(a_res_empty_after_rst, i_clk, !i_rst_n |=> !i_res_valid, "result after reset")
    `BB3_ASSERT(a_in_ready_after_rst, i_clk, !i_rst_n |=> i_in_ready, "input blocked after reset")
    `BB3_ASSERT_RST(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_red) && $stable(i_res_green) && $stable(i_res_blue) && $stable(i_res_last), "stalled result changed")

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_red   (o_res.red_out),
    .i_res_green (o_res.green_out),
    .i_res_blue  (o_res.blue_out),
    .i_res_last  (o_res.frame_end)
);
